// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/wnve_pkg.sv =====
package wnve_pkg;

   // default configuration of the block
   localparam int HISTORY_DEPTH_DEF = 512;
   localparam int FRACTION_BITS_DEF = 8;

   // field widths
   localparam int PRICE_W    = 20;
   localparam int NOISE_W    = 63;
   localparam int WINDOW_W   = 9;
   localparam int STRIDE_W   = 6;
   localparam int SEEN_W     = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [PRICE_W-1:0]   price_type;

   // register indexes
   localparam csr_idx_type CSR_WINDOW = 1'd0;
   localparam csr_idx_type CSR_STRIDE = 1'd1;

   // register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd300;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 6'd5;

   // sample counter limits and stride floor
   localparam logic [SEEN_W-1:0]   COUNT_MAX   = 10'd1023;
   localparam logic [SEEN_W-1:0]   MIN_SAMPLES = 10'd3;
   localparam logic [STRIDE_W-1:0] STRIDE_MIN  = 6'd2;

endpackage

// ===== hw/rtl/wnve_ram.sv =====
module wnve_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/windowed_noise_variance_estimator_core.sv =====
// a new item is taken only in idle, once the result of the last one is in the result
//   register; span = newest index - start (at most the window), DIV_W = 63 at default settings
// work on an item is serialized by the single history read port,
//   the shared squarer and the one-bit-per-cycle restoring divider
// reset: synchronous, active high; clears counters, configuration registers, state and
//   handshake state, history memory is not cleared (every entry is written before it is read)
`include "assert_macros.svh"

module windowed_noise_variance_estimator_core #(
   parameter int HISTORY_DEPTH = wnve_pkg::HISTORY_DEPTH_DEF,
   parameter int FRACTION_BITS = wnve_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wnve_pkg::PRICE_W-1:0]         req_price,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wnve_pkg::NOISE_W-1:0]  rsp_noise_variance,
   output logic                                 rsp_estimate_valid,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wnve_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wnve_pkg::CSR_DATA_W-1:0]      csr_data
);

   import wnve_pkg::*;

   // address width of the history and a working width for index math
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int XW = ((AW > SEEN_W) ? AW : SEEN_W) + 1;
   // squared difference, sums over the history, stride times sum
   localparam int SQ_W   = 2 * PRICE_W;
   localparam int SUM_W  = SQ_W + AW;
   localparam int PROD_W = SUM_W + STRIDE_W;
   // divider word: scaled magnitude, at least wide enough to see saturation
   localparam int DIV_W  = (PROD_W + FRACTION_BITS > NOISE_W) ?
                           (PROD_W + FRACTION_BITS) : NOISE_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);
   localparam int DVS_W  = STRIDE_W + 1;
   localparam int RES_W  = NOISE_W - 1;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_WALK  = 4'd2;
   localparam logic [3:0] ST_TURN  = 4'd3;
   localparam logic [3:0] ST_DRAIN = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUB   = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   localparam logic [AW:0] DEPTH_X = (AW+1)'(HISTORY_DEPTH);

   // control and configuration
   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       wp_ff, wp_in;
   logic [AW-1:0]       newest_ff, newest_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   // walk over the history
   logic [STRIDE_W-1:0] m_ff, m_in;
   logic [AW-1:0]       span_ff, span_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [AW-1:0]       back_ff, back_in;
   logic [STRIDE_W-1:0] step_ff, step_in;
   logic                phase_ff, phase_in;
   logic                first_ff, first_in;

   // read / square / accumulate pipeline
   logic                rd_v_ff, rd_v_in;
   logic                rd_first_ff, rd_first_in;
   logic                rd_tag_ff, rd_tag_in;
   logic [PRICE_W-1:0]  prev_ff, prev_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                sq_v_ff, sq_v_in;
   logic                sq_tag_ff, sq_tag_in;
   logic [SUM_W-1:0]    rv_ff, rv_in;
   logic [SUM_W-1:0]    rvm_ff, rvm_in;

   // combine and divide
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic [DIV_W-1:0]    quot_ff, quot_in;
   logic [DVS_W-1:0]    drem_ff, drem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                est_ff, est_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [NOISE_W-1:0] rsp_noise_ff, rsp_noise_in;
   logic                      rsp_est_ff, rsp_est_in;

   // history memory ports
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [PRICE_W-1:0] mem_rd_data;

   // combinational helpers
   logic                req_take;
   logic [SEEN_W-1:0]   idx_c;
   logic [STRIDE_W-1:0] m_c;
   logic [XW-1:0]       idx_x, m_x, w_x, cap_x, s_x;
   logic [AW:0]         back_x;
   logic [AW:0]         start_x;
   logic [AW:0]         addr_step_x;
   logic [PRICE_W-1:0]  absdiff_c;
   logic [PROD_W-1:0]   rvm_x;
   logic [DVS_W:0]      trial_c;
   logic                sat_c;
   logic [RES_W-1:0]    res_c;
   logic [NOISE_W-1:0]  res_x;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign mem_wr_en = req_take;
   assign mem_rd_en = (state_ff == ST_WALK);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_noise_variance = rsp_noise_ff;
   assign rsp_estimate_valid = rsp_est_ff;

   wnve_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_price),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   // window bounds from the newest index; the window is capped so that window plus stride fits below the depth
   always_comb begin
      idx_c = seen_ff - 1'b1;
      m_c   = (stride_ff < STRIDE_MIN) ? STRIDE_MIN : stride_ff;
      idx_x = XW'(idx_c);
      m_x   = XW'(m_c);
      cap_x = XW'(HISTORY_DEPTH - 1) - m_x;
      w_x   = (XW'(window_ff) > cap_x) ? cap_x : XW'(window_ff);
      s_x   = (idx_x > w_x && (idx_x - w_x) > m_x) ? (idx_x - w_x) : m_x;
   end

   // look-back distance for the first read of a walk: span+1 or span+stride
   assign back_x = (state_ff == ST_SETUP) ? ((AW+1)'(idx_x - s_x) + 1'b1)
                                          : ((AW+1)'(span_ff) + (AW+1)'(m_ff));

   // slot of the sample that lies back_x before the newest one
   assign start_x = ((AW+1)'(newest_ff) >= back_x) ? ((AW+1)'(newest_ff) - back_x)
                                                   : ((AW+1)'(newest_ff) + DEPTH_X - back_x);

   // circular advance of the read address
   always_comb begin
      addr_step_x = (AW+1)'(addr_ff) + (AW+1)'(step_ff);
      if (addr_step_x >= DEPTH_X) begin
         addr_step_x = addr_step_x - DEPTH_X;
      end
   end

   assign absdiff_c = (mem_rd_data >= prev_ff) ? (mem_rd_data - prev_ff)
                                               : (prev_ff - mem_rd_data);
   assign rvm_x     = PROD_W'(rvm_ff);
   assign trial_c   = {drem_ff, quot_ff[DIV_W-1]};

   // saturate when the scaled quotient reaches 2^62
   assign sat_c = |quot_ff[DIV_W-1:RES_W];
   assign res_c = sat_c ? {RES_W{1'b1}} : quot_ff[RES_W-1:0];
   assign res_x = {1'b0, res_c};

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      newest_in   = newest_ff;
      seen_in     = seen_ff;
      window_in   = window_ff;
      stride_in   = stride_ff;
      m_in        = m_ff;
      span_in     = span_ff;
      addr_in     = addr_ff;
      back_in     = back_ff;
      step_in     = step_ff;
      phase_in    = phase_ff;
      first_in    = first_ff;
      rd_v_in     = 1'b0;
      rd_first_in = rd_first_ff;
      rd_tag_in   = rd_tag_ff;
      prev_in     = prev_ff;
      sq_in       = sq_ff;
      sq_v_in     = 1'b0;
      sq_tag_in   = sq_tag_ff;
      rv_in       = rv_ff;
      rvm_in      = rvm_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      quot_in     = quot_ff;
      drem_in     = drem_ff;
      dvs_in      = dvs_ff;
      cnt_in      = cnt_ff;
      est_in      = est_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_noise_in = rsp_noise_ff;
      rsp_est_in   = rsp_est_ff;

      // register writes, only while idle; the user is bound to this, the block itself does not enforce it
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW: window_in = csr_data[WINDOW_W-1:0];
            CSR_STRIDE: stride_in = csr_data[STRIDE_W-1:0];
            default: begin
            end
         endcase
      end

      // square stage: difference against the previous read of the walk
      if (rd_v_ff) begin
         prev_in = mem_rd_data;
         if (!rd_first_ff) begin
            sq_in     = SQ_W'(absdiff_c) * SQ_W'(absdiff_c);
            sq_v_in   = 1'b1;
            sq_tag_in = rd_tag_ff;
         end
      end

      // accumulate stage: fine scale or coarse scale sum
      if (sq_v_ff) begin
         if (sq_tag_ff) begin
            rvm_in = rvm_ff + SUM_W'(sq_ff);
         end else begin
            rv_in = rv_ff + SUM_W'(sq_ff);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               newest_in = wp_ff;
               wp_in     = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : (wp_ff + 1'b1);
               if (seen_ff != COUNT_MAX) begin
                  seen_in = seen_ff + 1'b1;
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            quot_in = '0;
            neg_in  = 1'b0;
            rv_in   = '0;
            rvm_in  = '0;
            m_in    = m_c;
            if (seen_ff < MIN_SAMPLES) begin
               // too few samples: zero, not yet valid
               est_in   = 1'b0;
               state_in = ST_DONE;
            end else if (s_x > idx_x) begin
               // newest index still below the stride: empty sums
               est_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               est_in   = 1'b1;
               span_in  = AW'(idx_x - s_x);
               addr_in  = start_x[AW-1:0];
               back_in  = back_x[AW-1:0];
               step_in  = STRIDE_W'(1);
               phase_in = 1'b0;
               first_in = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_v_in     = 1'b1;
            rd_first_in = first_ff;
            rd_tag_in   = phase_ff;
            first_in    = 1'b0;
            if (back_ff >= AW'(step_ff)) begin
               back_in = back_ff - AW'(step_ff);
               addr_in = addr_step_x[AW-1:0];
            end else if (!phase_ff) begin
               state_in = ST_TURN;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_TURN: begin
            // coarse walk starts one stride before the window start
            addr_in  = start_x[AW-1:0];
            back_in  = back_x[AW-1:0];
            step_in  = m_ff;
            phase_in = 1'b1;
            first_in = 1'b1;
            state_in = ST_WALK;
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !sq_v_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(rv_ff) * PROD_W'(m_ff);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (prod_ff >= rvm_x) begin
               neg_in  = 1'b0;
               quot_in = DIV_W'(prod_ff - rvm_x) << FRACTION_BITS;
            end else begin
               neg_in  = 1'b1;
               quot_in = DIV_W'(rvm_x - prod_ff) << FRACTION_BITS;
            end
            drem_in  = '0;
            dvs_in   = {m_ff - 1'b1, 1'b0};
            cnt_in   = CNT_W'(DIV_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (trial_c >= (DVS_W+1)'(dvs_ff)) begin
               drem_in = DVS_W'(trial_c - (DVS_W+1)'(dvs_ff));
               quot_in = {quot_ff[DIV_W-2:0], 1'b1};
            end else begin
               drem_in = trial_c[DVS_W-1:0];
               quot_in = {quot_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_noise_in = neg_ff ? (NOISE_W'(0) - res_x) : res_x;
               rsp_est_in   = est_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         seen_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         stride_ff    <= STRIDE_RESET;
         rd_v_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         window_ff    <= window_in;
         stride_ff    <= stride_in;
         rd_v_ff      <= rd_v_in;
         sq_v_ff      <= sq_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      newest_ff    <= newest_in;
      m_ff         <= m_in;
      span_ff      <= span_in;
      addr_ff      <= addr_in;
      back_ff      <= back_in;
      step_ff      <= step_in;
      phase_ff     <= phase_in;
      first_ff     <= first_in;
      rd_first_ff  <= rd_first_in;
      rd_tag_ff    <= rd_tag_in;
      prev_ff      <= prev_in;
      sq_ff        <= sq_in;
      sq_tag_ff    <= sq_tag_in;
      rv_ff        <= rv_in;
      rvm_ff       <= rvm_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      quot_ff      <= quot_in;
      drem_ff      <= drem_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      est_ff       <= est_in;
      rsp_noise_ff <= rsp_noise_in;
      rsp_est_ff   <= rsp_est_in;
   end

   // an accepted item always starts the setup step
   `ASSERT_NEXT(a_accept_setup, req_take, state_ff == ST_SETUP, "item accepted outside idle")
   // a held result is never overwritten
   `ASSERT_NEXT(a_done_holds, state_ff == ST_DONE && rsp_valid_ff && rsp_stall,
                state_ff == ST_DONE, "result register overwritten while stalled")
   // sums are complete before they are combined
   `ASSERT_IMPLIES(a_drained, state_ff == ST_MUL, !rd_v_ff && !sq_v_ff,
                   "square pipeline not empty at multiply")
   // partial remainder stays below the divisor
   `ASSERT_IMPLIES(a_div_rem, state_ff == ST_DIV, drem_ff < dvs_ff,
                   "divider remainder out of range")

endmodule
